[rtl/add_order_frame_decoder_top_defines.svh]
// ----------------------------------------------------------------------------
// Add order frame decoder assertion macros
// Shared concurrent assertion forms for the checker of the decoder.
// ----------------------------------------------------------------------------
`ifndef ADD_ORDER_FRAME_DECODER_TOP_DEFINES_SVH
`define ADD_ORDER_FRAME_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AOFD_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("add order frame decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AOFD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("add order frame decoder check failed");

`endif

[rtl/aofd_pkg.sv]
// ----------------------------------------------------------------------------
// Add order frame decoder package
// Word types, frame layout constants and status codes of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package aofd_pkg;

    typedef logic [5:0] t_pos;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_byte_word;

    typedef struct packed {
        logic               status;
        logic [63:0]        sequence_number;
        logic [63:0]        order_ident;
        logic               side_sell;
        logic signed [31:0] price_value;
        logic signed [31:0] quantity_value;
    } t_result_word;

    localparam logic STATUS_DECODED = 1'b0;
    localparam logic STATUS_ERROR   = 1'b1;

    localparam int unsigned FRAME_LENGTH = 32;

    localparam logic [7:0] WIRE_VERSION   = 8'd1;
    localparam logic [7:0] MSG_TYPE_ADD   = 8'd1;
    localparam logic [7:0] SIDE_CODE_BUY  = 8'd1;
    localparam logic [7:0] SIDE_CODE_SELL = 8'd2;
    localparam logic [7:0] SIZE_CODE_HI   = 8'((FRAME_LENGTH >> 8) & 255);
    localparam logic [7:0] SIZE_CODE_LO   = 8'(FRAME_LENGTH & 255);

    localparam t_pos POS_VERSION        = 6'd0;
    localparam t_pos POS_TYPE           = 6'd1;
    localparam t_pos POS_LEN_HI         = 6'd2;
    localparam t_pos POS_LEN_LO         = 6'd3;
    localparam t_pos POS_SEQ_FIRST      = 6'd4;
    localparam t_pos POS_SEQ_LAST       = 6'd11;
    localparam t_pos POS_IDENT_FIRST    = 6'd12;
    localparam t_pos POS_IDENT_LAST     = 6'd19;
    localparam t_pos POS_SIDE           = 6'd20;
    localparam t_pos POS_RESERVED_FIRST = 6'd21;
    localparam t_pos POS_RESERVED_LAST  = 6'd23;
    localparam t_pos POS_PRICE_FIRST    = 6'd24;
    localparam t_pos POS_PRICE_LAST     = 6'd27;
    localparam t_pos POS_QTY_FIRST      = 6'd28;
    localparam t_pos POS_FRAME_LAST     = 6'(FRAME_LENGTH - 1);
    localparam t_pos POS_BEYOND         = 6'(FRAME_LENGTH);
    localparam t_pos POS_MAX            = 6'd63;

endpackage

`default_nettype wire

[rtl/aofd_stream_if.sv]
// ----------------------------------------------------------------------------
// Add order frame decoder channels
// Valid/ready channels for frame bytes and for decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface aofd_byte_if import aofd_pkg::*;;
    logic       valid;
    logic       ready;
    t_byte_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface aofd_result_if import aofd_pkg::*;;
    logic         valid;
    logic         ready;
    t_result_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/add_order_frame_decoder_top.sv]
// ----------------------------------------------------------------------------
// Add order frame decoder
// Checks and decodes a 32-byte add order frame that arrives one byte a word.
//
// Channel  Dir  Word          Contents
// i_in     in   t_byte_word   data_byte, frame_end
// o_out    out  t_result_word status, sequence_number, order_ident,
//                             side_sell, price_value, quantity_value
//
// One byte is taken per cycle; a result word is registered and appears the
// cycle after its frame's last byte is accepted.
// The result register decouples the sides: i_in stalls only when a result is
// waiting and o_out is not ready.
// Reset is synchronous, active low, and restarts the frame at byte zero.
// ----------------------------------------------------------------------------
`default_nettype none

module add_order_frame_decoder_top import aofd_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    aofd_byte_if.sink   i_in,
    aofd_result_if.source o_out
);

    t_pos         r_byte_index, n_byte_index;
    logic         r_frame_bad, n_frame_bad;
    logic [63:0]  r_seq_shift, n_seq_shift;
    logic [63:0]  r_ident_shift, n_ident_shift;
    logic         r_side_bit, n_side_bit;
    logic [31:0]  r_price_shift, n_price_shift;
    logic [31:0]  r_qty_shift, n_qty_shift;
    logic         r_out_valid, n_out_valid;
    t_result_word r_out_word, n_out_word;

    logic         w_accept;
    logic         w_fail;
    logic         w_bad;
    logic [7:0]   w_byte;
    t_pos         w_pos;

    assign i_in.ready    = !r_out_valid || o_out.ready;
    assign w_accept      = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_word;

    assign w_byte = i_in.payload.data_byte;
    assign w_pos  = r_byte_index;

    always_comb begin
        w_fail = 1'b0;
        if (w_pos >= POS_BEYOND) begin
            w_fail = 1'b1;
        end else if (w_pos == POS_VERSION) begin
            w_fail = (w_byte != WIRE_VERSION);
        end else if (w_pos == POS_TYPE) begin
            w_fail = (w_byte != MSG_TYPE_ADD);
        end else if (w_pos == POS_LEN_HI) begin
            w_fail = (w_byte != SIZE_CODE_HI);
        end else if (w_pos == POS_LEN_LO) begin
            w_fail = (w_byte != SIZE_CODE_LO);
        end else if (w_pos == POS_SIDE) begin
            w_fail = (w_byte != SIDE_CODE_BUY) && (w_byte != SIDE_CODE_SELL);
        end else if (w_pos inside {[POS_RESERVED_FIRST:POS_RESERVED_LAST]}) begin
            w_fail = (w_byte != 8'd0);
        end
    end

    always_comb begin
        n_byte_index  = r_byte_index;
        n_frame_bad   = r_frame_bad;
        n_seq_shift   = r_seq_shift;
        n_ident_shift = r_ident_shift;
        n_side_bit    = r_side_bit;
        n_price_shift = r_price_shift;
        n_qty_shift   = r_qty_shift;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_word    = r_out_word;
        w_bad         = 1'b0;

        if (w_accept) begin
            if (w_pos inside {[POS_SEQ_FIRST:POS_SEQ_LAST]}) begin
                n_seq_shift = {r_seq_shift[55:0], w_byte};
            end else if (w_pos inside {[POS_IDENT_FIRST:POS_IDENT_LAST]}) begin
                n_ident_shift = {r_ident_shift[55:0], w_byte};
            end else if (w_pos == POS_SIDE) begin
                n_side_bit = (w_byte == SIDE_CODE_SELL);
            end else if (w_pos inside {[POS_PRICE_FIRST:POS_PRICE_LAST]}) begin
                n_price_shift = {r_price_shift[23:0], w_byte};
            end else if (w_pos inside {[POS_QTY_FIRST:POS_FRAME_LAST]}) begin
                n_qty_shift = {r_qty_shift[23:0], w_byte};
            end

            n_frame_bad = r_frame_bad || w_fail;
            if (r_byte_index != POS_MAX) begin
                n_byte_index = r_byte_index + 6'd1;
            end

            if (i_in.payload.frame_end) begin
                w_bad       = n_frame_bad || (w_pos != POS_FRAME_LAST);
                n_out_valid = 1'b1;
                if (w_bad) begin
                    n_out_word        = '0;
                    n_out_word.status = STATUS_ERROR;
                end else begin
                    n_out_word.status          = STATUS_DECODED;
                    n_out_word.sequence_number = n_seq_shift;
                    n_out_word.order_ident     = n_ident_shift;
                    n_out_word.side_sell       = n_side_bit;
                    n_out_word.price_value     = signed'(n_price_shift);
                    n_out_word.quantity_value  = signed'(n_qty_shift);
                end
                n_byte_index = '0;
                n_frame_bad  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= '0;
            r_frame_bad  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_byte_index <= n_byte_index;
            r_frame_bad  <= n_frame_bad;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq_shift   <= n_seq_shift;
        r_ident_shift <= n_ident_shift;
        r_side_bit    <= n_side_bit;
        r_price_shift <= n_price_shift;
        r_qty_shift   <= n_qty_shift;
        r_out_word    <= n_out_word;
    end

endmodule

`default_nettype wire

[rtl/aofd_checker.sv]
// ----------------------------------------------------------------------------
// Add order frame decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "add_order_frame_decoder_top_defines.svh"

module aofd_checker import aofd_pkg::*; (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          i_in_valid,
    input wire          i_in_ready,
    input t_byte_word   i_in_word,
    input wire          i_out_valid,
    input wire          i_out_ready,
    input t_result_word i_out_word
);

    logic w_end_taken;
    logic w_out_stall;
    logic w_result_cause;
    logic w_err_shown;
    logic w_fields_zero;

    assign w_end_taken    = i_in_valid && i_in_ready && i_in_word.frame_end;
    assign w_out_stall    = i_out_valid && !i_out_ready;
    assign w_result_cause = w_end_taken || w_out_stall;
    assign w_err_shown    = i_out_valid && (i_out_word.status == STATUS_ERROR);
    assign w_fields_zero  = (i_out_word.sequence_number == 64'd0)
                         && (i_out_word.order_ident == 64'd0)
                         && !i_out_word.side_sell
                         && (i_out_word.price_value == 32'sd0)
                         && (i_out_word.quantity_value == 32'sd0);

    `AOFD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(i_out_word))

    `AOFD_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, w_end_taken, i_out_valid)

    `AOFD_ASSERT_SAME(a_result_has_cause, i_clk, i_rst_n, i_out_valid && $past(i_rst_n), $past(w_result_cause))

    `AOFD_ASSERT_SAME(a_error_fields_zero, i_clk, i_rst_n, w_err_shown, w_fields_zero)

endmodule

bind add_order_frame_decoder_top aofd_checker u_aofd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_word   (i_in.payload),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.payload)
);

`default_nettype wire

[tb/tb_add_order_frame_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Add order frame decoder testbench
// Streams add order frames, both well formed and broken, into the decoder one
// byte word at a time. A behavioral copy of the frame checks predicts each
// decoded result word, and the result words that come out are compared field
// by field against those predictions while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_add_order_frame_decoder_top import aofd_pkg::*;;

    localparam int unsigned SINK_HOLD_CYCLES = 200;
    localparam int unsigned PHASE_BYTES      = 140;
    localparam int unsigned PHASE_FRAMES     = 4;

    typedef struct {
        t_byte_word  word;
        int unsigned gap_pct;
        int unsigned stall_pct;
        bit          drain_first;
        bit          hold_sink;
    } t_byte_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    aofd_byte_if   in_if ();
    aofd_result_if out_if ();

    add_order_frame_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_byte_item   bytes_to_send [$];
    logic [7:0]   frame_buf [$];
    t_result_word decoded_frames_due [$];

    int unsigned phase_gap_pct = 0;
    int unsigned phase_stall_pct = 0;
    bit          next_drain = 1'b0;
    bit          next_hold = 1'b0;
    int unsigned sink_stall_pct = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned bytes_accepted = 0;
    int unsigned total_bytes = 0;
    int unsigned mismatch_count = 0;

    // Shadow of the decoder state for the frame in progress.
    t_pos        trk_pos = '0;
    logic        trk_bad = 1'b0;
    logic [63:0] trk_seq = '0;
    logic [63:0] trk_ident = '0;
    logic        trk_sell = 1'b0;
    logic [31:0] trk_price = '0;
    logic [31:0] trk_qty = '0;

    task automatic track_frame_byte(input t_byte_word w);
        t_pos         pos;
        t_result_word res;
        pos = trk_pos;
        if (pos >= POS_BEYOND) begin
            trk_bad = 1'b1;
        end else if (pos == POS_VERSION) begin
            if (w.data_byte != WIRE_VERSION) trk_bad = 1'b1;
        end else if (pos == POS_TYPE) begin
            if (w.data_byte != MSG_TYPE_ADD) trk_bad = 1'b1;
        end else if (pos == POS_LEN_HI) begin
            if (w.data_byte != SIZE_CODE_HI) trk_bad = 1'b1;
        end else if (pos == POS_LEN_LO) begin
            if (w.data_byte != SIZE_CODE_LO) trk_bad = 1'b1;
        end else if (pos == POS_SIDE) begin
            if (w.data_byte != SIDE_CODE_BUY && w.data_byte != SIDE_CODE_SELL) trk_bad = 1'b1;
        end else if (pos >= POS_RESERVED_FIRST && pos <= POS_RESERVED_LAST) begin
            if (w.data_byte != 8'd0) trk_bad = 1'b1;
        end

        if (pos >= POS_SEQ_FIRST && pos <= POS_SEQ_LAST) begin
            trk_seq = {trk_seq[55:0], w.data_byte};
        end else if (pos >= POS_IDENT_FIRST && pos <= POS_IDENT_LAST) begin
            trk_ident = {trk_ident[55:0], w.data_byte};
        end else if (pos == POS_SIDE) begin
            trk_sell = (w.data_byte == SIDE_CODE_SELL);
        end else if (pos >= POS_PRICE_FIRST && pos <= POS_PRICE_LAST) begin
            trk_price = {trk_price[23:0], w.data_byte};
        end else if (pos >= POS_QTY_FIRST && pos <= POS_FRAME_LAST) begin
            trk_qty = {trk_qty[23:0], w.data_byte};
        end

        if (trk_pos != POS_MAX) trk_pos = trk_pos + 6'd1;

        if (w.frame_end) begin
            if (pos != POS_FRAME_LAST) trk_bad = 1'b1;
            res = '0;
            if (trk_bad) begin
                res.status = STATUS_ERROR;
            end else begin
                res.status          = STATUS_DECODED;
                res.sequence_number = trk_seq;
                res.order_ident     = trk_ident;
                res.side_sell       = trk_sell;
                res.price_value     = trk_price;
                res.quantity_value  = trk_qty;
            end
            decoded_frames_due.push_back(res);
            trk_pos   = '0;
            trk_bad   = 1'b0;
            trk_seq   = '0;
            trk_ident = '0;
            trk_sell  = 1'b0;
            trk_price = '0;
            trk_qty   = '0;
        end
    endtask

    task automatic build_add_frame(input logic [63:0] seq, input logic [63:0] ident,
                                   input logic sell, input logic [31:0] price,
                                   input logic [31:0] qty);
        frame_buf = {};
        frame_buf.push_back(WIRE_VERSION);
        frame_buf.push_back(MSG_TYPE_ADD);
        frame_buf.push_back(SIZE_CODE_HI);
        frame_buf.push_back(SIZE_CODE_LO);
        for (int i = 7; i >= 0; i--) frame_buf.push_back(seq[i*8 +: 8]);
        for (int i = 7; i >= 0; i--) frame_buf.push_back(ident[i*8 +: 8]);
        frame_buf.push_back(sell ? SIDE_CODE_SELL : SIDE_CODE_BUY);
        repeat (3) frame_buf.push_back(8'd0);
        for (int i = 3; i >= 0; i--) frame_buf.push_back(price[i*8 +: 8]);
        for (int i = 3; i >= 0; i--) frame_buf.push_back(qty[i*8 +: 8]);
    endtask

    task automatic queue_frame();
        t_byte_item item;
        foreach (frame_buf[i]) begin
            item.word.data_byte = frame_buf[i];
            item.word.frame_end = (i == frame_buf.size() - 1);
            item.gap_pct        = phase_gap_pct;
            item.stall_pct      = phase_stall_pct;
            item.drain_first    = (i == 0) && next_drain;
            item.hold_sink      = (i == 0) && next_hold;
            bytes_to_send.push_back(item);
        end
        next_drain = 1'b0;
        next_hold  = 1'b0;
    endtask

    task automatic queue_random_frame();
        t_pos        checked_pos [8] = '{POS_VERSION, POS_TYPE, POS_LEN_HI, POS_LEN_LO,
                                         POS_SIDE, POS_RESERVED_FIRST, 6'd22,
                                         POS_RESERVED_LAST};
        int unsigned kind;
        int unsigned n;
        t_pos        pos;
        logic [7:0]  v;
        build_add_frame({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(1)),
                        $urandom, $urandom);
        kind = $urandom_range(99);
        if (kind >= 60 && kind < 75) begin
            pos = checked_pos[$urandom_range(7)];
            if (pos == POS_SIDE) begin
                do v = 8'($urandom_range(255));
                while (v == SIDE_CODE_BUY || v == SIDE_CODE_SELL);
                frame_buf[pos] = v;
            end else begin
                frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(255, 1));
            end
        end else if (kind >= 75 && kind < 83) begin
            n = $urandom_range(31, 1);
            while (frame_buf.size() > n) void'(frame_buf.pop_back());
        end else if (kind >= 83 && kind < 91) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 33) : $urandom_range(4, 1);
            repeat (n) frame_buf.push_back(8'($urandom_range(255)));
        end else if (kind >= 91) begin
            frame_buf = {};
            n = $urandom_range(40, 1);
            repeat (n) frame_buf.push_back(8'($urandom_range(255)));
        end
        queue_frame();
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : drive_bytes
        t_byte_item head;
        logic       offer;
        logic       start_hold;
        start_hold = 1'b0;
        if (!i_rst_n) begin
            in_if.valid   <= 1'b0;
            in_if.payload <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                track_frame_byte(in_if.payload);
                bytes_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                offer = 1'b0;
                if (bytes_to_send.size() != 0) begin
                    head = bytes_to_send[0];
                    if (!(head.drain_first && decoded_frames_due.size() != 0)
                        && $urandom_range(99) >= head.gap_pct) begin
                        offer = 1'b1;
                        void'(bytes_to_send.pop_front());
                        in_if.payload  <= head.word;
                        sink_stall_pct <= head.stall_pct;
                        start_hold     = head.hold_sink;
                    end
                end
                in_if.valid <= offer;
            end
        end
        hold_request <= start_hold;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_request) begin
            hold_left <= SINK_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_result_word want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (decoded_frames_due.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, out_if.payload);
                    mismatch_count++;
                end else begin
                    want = decoded_frames_due.pop_front();
                    compare_field("status", 64'(out_if.payload.status), 64'(want.status));
                    compare_field("sequence_number", out_if.payload.sequence_number,
                                  want.sequence_number);
                    compare_field("order_ident", out_if.payload.order_ident,
                                  want.order_ident);
                    compare_field("side_sell", 64'(out_if.payload.side_sell),
                                  64'(want.side_sell));
                    compare_field("price_value", 64'(out_if.payload.price_value),
                                  64'(want.price_value));
                    compare_field("quantity_value", 64'(out_if.payload.quantity_value),
                                  64'(want.quantity_value));
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        int unsigned gap_by_phase [4]   = '{0, 51, 0, 15};
        int unsigned stall_by_phase [4] = '{0, 0, 51, 15};
        int unsigned phase_start;
        int unsigned phase_frames;

        build_add_frame('0, '0, 1'b0, '0, '0);
        queue_frame();
        build_add_frame('1, '1, 1'b1, 32'h7fff_ffff, 32'h8000_0000);
        queue_frame();
        build_add_frame(64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 1'b0,
                        32'h8000_0000, 32'h7fff_ffff);
        queue_frame();
        frame_buf = {WIRE_VERSION};
        queue_frame();
        build_add_frame('1, '0, 1'b1, '1, '1);
        void'(frame_buf.pop_back());
        queue_frame();
        build_add_frame('0, '1, 1'b0, '0, '1);
        frame_buf.push_back(8'h00);
        queue_frame();
        build_add_frame({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, $urandom, $urandom);
        repeat (38) frame_buf.push_back(8'($urandom_range(255)));
        queue_frame();

        for (int p = 0; p < 4; p++) begin
            phase_gap_pct   = gap_by_phase[p];
            phase_stall_pct = stall_by_phase[p];
            next_drain      = 1'b1;
            next_hold       = (p == 0);
            phase_start     = bytes_to_send.size();
            phase_frames    = 0;
            while (bytes_to_send.size() - phase_start < PHASE_BYTES
                   || phase_frames < PHASE_FRAMES) begin
                queue_random_frame();
                phase_frames++;
            end
        end
        total_bytes = bytes_to_send.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_accepted < total_bytes) @(posedge i_clk);
        while (decoded_frames_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timed out with %0d result words outstanding", $time,
                 decoded_frames_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
